/* sv/rwsf_pkg.sv */
// Shared constants, tables and types of the register-write SysEx framer.
package rwsf_pkg;

  localparam int MAX_CHIPS     = 4;
  localparam int REGS_PER_CHIP = 28;
  localparam int NUM_ENTRIES   = MAX_CHIPS * REGS_PER_CHIP;
  localparam int ENTRY_W       = $clog2(NUM_ENTRIES);

  localparam logic [7:0] SOX       = 8'hF0;
  localparam logic [7:0] MFR_ID    = 8'h2D;
  localparam logic [7:0] EOX       = 8'hF7;
  localparam logic [7:0] LOW7_MASK = 8'h7F;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // voice control registers, their secondary slots and the forcing range
  localparam logic [4:0] REG_VC1   = 5'h04;
  localparam logic [4:0] REG_VC2   = 5'h0B;
  localparam logic [4:0] REG_VC3   = 5'h12;
  localparam logic [4:0] REG_SEC1  = 5'h19;
  localparam logic [4:0] REG_SEC2  = 5'h1A;
  localparam logic [4:0] REG_SEC3  = 5'h1B;
  localparam logic [4:0] REG_FORCE_LO = 5'h16;
  localparam logic [4:0] REG_FORCE_HI = 5'h18;

  // one frame byte handed to the packer
  typedef struct packed {
    logic       vld;
    logic [7:0] value;
    logic       eof;
    logic       last;
  } push_t;

  function automatic logic [7:0] chip_addr(logic [1:0] c);
    logic [7:0] a;
    unique case (c)
      2'd0: a = 8'h4E;
      2'd1: a = 8'h50;
      2'd2: a = 8'h51;
      2'd3: a = 8'h52;
    endcase
    return a;
  endfunction

  // register visited at each position of the frame's map order
  function automatic logic [4:0] scan_reg(logic [4:0] i);
    logic [4:0] r;
    unique case (i)
      5'd0:  r = 5'd0;
      5'd1:  r = 5'd1;
      5'd2:  r = 5'd2;
      5'd3:  r = 5'd3;
      5'd4:  r = 5'd5;
      5'd5:  r = 5'd6;
      5'd6:  r = 5'd7;
      5'd7:  r = 5'd8;
      5'd8:  r = 5'd9;
      5'd9:  r = 5'd10;
      5'd10: r = 5'd12;
      5'd11: r = 5'd13;
      5'd12: r = 5'd14;
      5'd13: r = 5'd15;
      5'd14: r = 5'd16;
      5'd15: r = 5'd17;
      5'd16: r = 5'd19;
      5'd17: r = 5'd20;
      5'd18: r = 5'd21;
      5'd19: r = 5'd22;
      5'd20: r = 5'd23;
      5'd21: r = 5'd24;
      5'd22: r = 5'd4;
      5'd23: r = 5'd11;
      5'd24: r = 5'd18;
      5'd25: r = 5'd25;
      5'd26: r = 5'd26;
      5'd27: r = 5'd27;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // chip * 28 + reg
  function automatic logic [ENTRY_W-1:0] entry(logic [1:0] c, logic [4:0] r);
    return {c, 5'b0} - {3'b0, c, 2'b0} + {2'b0, r};
  endfunction

  function automatic logic is_vc(logic [4:0] r);
    return (r == REG_VC1) || (r == REG_VC2) || (r == REG_VC3);
  endfunction

  function automatic logic is_force(logic [4:0] r);
    return (r >= REG_FORCE_LO) && (r <= REG_FORCE_HI);
  endfunction

  function automatic logic [4:0] sec_of(logic [4:0] r);
    logic [4:0] s;
    priority if (r == REG_VC1) s = REG_SEC1;
    else if (r == REG_VC2)     s = REG_SEC2;
    else                       s = REG_SEC3;
    return s;
  endfunction

endpackage

/* sv/rwsf_ram.sv */
// Generic single-port-write, registered-read RAM.
module rwsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rwsf_packer.sv */
// Packs frame bytes four to a result word (fewer in the word that ends a frame) and registers the result.
module rwsf_packer (
  input  logic           clk,
  input  logic           rst,
  input  rwsf_pkg::push_t push,
  output logic           strobe,
  output logic [7:0]     byte_a,
  output logic [7:0]     byte_b,
  output logic [7:0]     byte_c,
  output logic [7:0]     byte_d,
  output logic [2:0]     byte_count,
  output logic           frame_end,
  output logic           last
);
  import rwsf_pkg::*;

  logic [2:0][7:0] hold;
  logic [1:0]      fill;
  logic            emit;
  logic [3:0][7:0] word;

  assign emit = push.vld && (push.eof || fill == 2'd3);

  always_comb begin
    word[0] = (fill == 2'd0) ? push.value : hold[0];
    word[1] = (fill == 2'd1) ? push.value : ((fill > 2'd1) ? hold[1] : 8'h00);
    word[2] = (fill == 2'd2) ? push.value : ((fill > 2'd2) ? hold[2] : 8'h00);
    word[3] = (fill == 2'd3) ? push.value : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
      if (push.vld) begin
        if (emit) begin
          fill <= 2'd0;
        end else begin
          hold[fill] <= push.value;
          fill       <= fill + 2'd1;
        end
      end
    end
    if (emit) begin
      byte_a     <= word[0];
      byte_b     <= word[1];
      byte_c     <= word[2];
      byte_d     <= word[3];
      byte_count <= {1'b0, fill} + 3'd1;
      frame_end  <= push.eof;
      last       <= push.last;
    end
  end

endmodule

/* sv/register_write_sysex_framer_core.sv */
// Top level of the register-write SysEx framer.
//
// Items enter on start while busy is low: opcode selects a register write
// (chip, reg_addr, data) or a flush. Configuration: cfg_we writes cfg_data
// into active_chips (reset 1); the user must do so only while the block is
// idle, which the block itself does not enforce. A first or ignored write
// completes in the idle state; a repeated write to a voice control
// register with a marked secondary slot goes through read, move back and
// store. A flush walks each active chip: it scans the shadow RAM for the
// MSB mask, sends the masks, re-reads the modified bytes and closes the
// frame. A forcing write to a marked register flushes first; a retry state
// then stores it if its mark was cleared. Results leave as words of up to
// four bytes, one word per strobe cycle, through an output register; the
// receiver cannot stall, so words are never held back. last marks the
// final word of an item. Reset clears the marks and the written-flags of
// the shadow file, so every register reads as zero until written.
module register_write_sysex_framer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [1:0] chip,
  input  logic [4:0] reg_addr,
  input  logic [7:0] data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  output logic       strobe,
  output logic [7:0] byte_a,
  output logic [7:0] byte_b,
  output logic [7:0] byte_c,
  output logic [7:0] byte_d,
  output logic [2:0] byte_count,
  output logic       frame_end,
  output logic       last
);
  import rwsf_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SEC_PRIM = 4'd1;
  localparam logic [3:0] S_SEC_WR   = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_MASK     = 4'd4;
  localparam logic [3:0] S_DATA     = 4'd5;
  localparam logic [3:0] S_END      = 4'd6;
  localparam logic [3:0] S_RETRY    = 4'd7;

  localparam logic [4:0] SCAN_LEN  = 5'(REGS_PER_CHIP);
  localparam logic [4:0] MASK_LAST = 5'd7;

  logic [3:0]             state;
  logic [2:0]             active_chips;
  logic [1:0]             it_chip;
  logic [4:0]             it_reg;
  logic [7:0]             it_data;
  logic                   retry;
  logic [1:0]             cc;
  logic [4:0]             step;
  logic [REGS_PER_CHIP-1:0] mod_mask;
  logic [REGS_PER_CHIP-1:0] msb_mask;
  logic                   rd_pend;
  logic                   rd_pend_next;
  logic [4:0]             pend_i;
  logic [NUM_ENTRIES-1:0] marks;
  logic [NUM_ENTRIES-1:0] written;
  logic                   rd_valid;

  logic                   we;
  logic [ENTRY_W-1:0]     waddr;
  logic [7:0]             wdata;
  logic [ENTRY_W-1:0]     raddr;
  logic [7:0]             rdata;
  logic [7:0]             rd_byte;
  logic                   mark_set;
  logic [ENTRY_W-1:0]     mark_idx;
  logic                   mark_clr;
  push_t                  push;

  logic                   acc;
  logic                   in_ok;
  logic [2:0]             lim;
  logic                   last_chip;
  logic [ENTRY_W-1:0]     in_idx;
  logic [ENTRY_W-1:0]     sec_idx;
  logic [ENTRY_W-1:0]     it_idx;
  logic [ENTRY_W-1:0]     it_sec_idx;
  logic [ENTRY_W-1:0]     scan_idx;
  logic [6:0]             mask_grp;

  assign busy      = (state != S_IDLE);
  assign acc       = start && !busy;
  assign in_ok     = (reg_addr < SCAN_LEN);
  assign lim       = (active_chips > 3'(MAX_CHIPS)) ? 3'(MAX_CHIPS) : active_chips;
  assign last_chip = ({1'b0, cc} == lim - 3'd1);
  assign in_idx    = entry(chip, reg_addr);
  assign sec_idx   = entry(chip, sec_of(reg_addr));
  assign it_idx    = entry(it_chip, it_reg);
  assign it_sec_idx = entry(it_chip, sec_of(it_reg));
  assign scan_idx  = entry(cc, scan_reg(step));
  assign rd_byte   = rd_valid ? rdata : 8'h00;
  assign mask_grp  = step[2] ? msb_mask[7*step[1:0] +: 7] : mod_mask[7*step[1:0] +: 7];

  rwsf_ram #(
    .WIDTH(8),
    .DEPTH(NUM_ENTRIES)
  ) u_shadow (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  rwsf_packer u_pack (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .strobe    (strobe),
    .byte_a    (byte_a),
    .byte_b    (byte_b),
    .byte_c    (byte_c),
    .byte_d    (byte_d),
    .byte_count(byte_count),
    .frame_end (frame_end),
    .last      (last)
  );

  // datapath steering: shadow RAM ports, mark updates, frame bytes
  always_comb begin
    we           = 1'b0;
    waddr        = in_idx;
    wdata        = data;
    raddr        = sec_idx;
    mark_set     = 1'b0;
    mark_idx     = in_idx;
    mark_clr     = 1'b0;
    push         = '0;
    rd_pend_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc && opcode == OP_WRITE && in_ok) begin
          if (!marks[in_idx]) begin
            we       = 1'b1;
            mark_set = 1'b1;
          end else if (is_vc(reg_addr) && !marks[sec_idx]) begin
            we       = 1'b1;
            waddr    = sec_idx;
            mark_set = 1'b1;
            mark_idx = sec_idx;
          end
        end
      end
      S_SEC_PRIM: begin
        // move the older secondary value back into the primary
        we    = 1'b1;
        waddr = it_idx;
        wdata = rd_byte;
      end
      S_SEC_WR: begin
        we    = 1'b1;
        waddr = it_sec_idx;
        wdata = it_data;
      end
      S_SCAN: begin
        raddr        = scan_idx;
        rd_pend_next = (step < SCAN_LEN);
        if (step < 5'd3) begin
          push.vld = 1'b1;
          priority if (step == 5'd0) push.value = SOX;
          else if (step == 5'd1)     push.value = MFR_ID;
          else                       push.value = chip_addr(cc);
        end
      end
      S_MASK: begin
        push.vld   = 1'b1;
        push.value = {1'b0, mask_grp};
      end
      S_DATA: begin
        raddr        = scan_idx;
        rd_pend_next = (step < SCAN_LEN) && marks[scan_idx];
        if (rd_pend) begin
          push.vld   = 1'b1;
          push.value = rd_byte & LOW7_MASK;
        end
      end
      S_END: begin
        push.vld   = 1'b1;
        push.value = EOX;
        push.eof   = 1'b1;
        push.last  = last_chip;
        mark_clr   = 1'b1;
      end
      S_RETRY: begin
        if (!marks[it_idx]) begin
          we       = 1'b1;
          waddr    = it_idx;
          wdata    = it_data;
          mark_set = 1'b1;
          mark_idx = it_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_valid <= written[raddr];
    if (rst) begin
      state        <= S_IDLE;
      active_chips <= 3'd1;
      marks        <= '0;
      written      <= '0;
      rd_pend      <= 1'b0;
      retry        <= 1'b0;
      cc           <= 2'd0;
      step         <= 5'd0;
    end else begin
      if (cfg_we) begin
        active_chips <= cfg_data;
      end
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (mark_set) begin
        marks[mark_idx] <= 1'b1;
      end
      if (mark_clr) begin
        for (int c = 0; c < MAX_CHIPS; c++) begin
          for (int r = 0; r < REGS_PER_CHIP; r++) begin
            if (cc == 2'(c)) begin
              marks[c*REGS_PER_CHIP + r] <= 1'b0;
            end
          end
        end
      end
      rd_pend <= rd_pend_next;

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            it_chip <= chip;
            it_reg  <= reg_addr;
            it_data <= data;
            retry   <= 1'b0;
            cc      <= 2'd0;
            step    <= 5'd0;
            if (opcode == OP_FLUSH) begin
              state <= (lim == 3'd0) ? S_IDLE : S_SCAN;
            end else if (in_ok && marks[in_idx]) begin
              if (is_vc(reg_addr) && marks[sec_idx]) begin
                state <= S_SEC_PRIM;
              end else if (is_force(reg_addr)) begin
                // flush first, then store the write if its mark was cleared
                retry <= 1'b1;
                state <= (lim == 3'd0) ? S_IDLE : S_SCAN;
              end
            end
          end
        end
        S_SEC_PRIM: state <= S_SEC_WR;
        S_SEC_WR:   state <= S_IDLE;
        S_SCAN: begin
          if (rd_pend) begin
            msb_mask[pend_i] <= rd_byte[7];
          end
          if (step < SCAN_LEN) begin
            mod_mask[step] <= marks[scan_idx];
            pend_i         <= step;
            step           <= step + 5'd1;
          end else begin
            step  <= 5'd0;
            state <= S_MASK;
          end
        end
        S_MASK: begin
          if (step == MASK_LAST) begin
            step  <= 5'd0;
            state <= S_DATA;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_DATA: begin
          if (step < SCAN_LEN) begin
            step <= step + 5'd1;
          end else begin
            state <= S_END;
          end
        end
        S_END: begin
          step <= 5'd0;
          if (last_chip) begin
            state <= retry ? S_RETRY : S_IDLE;
          end else begin
            cc    <= cc + 2'd1;
            state <= S_SCAN;
          end
        end
        S_RETRY: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/rwsf_checker.sv */
// Port-level checks on the framer core, bound to the top level.
module rwsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       opcode,
  input logic [4:0] reg_addr,
  input logic       strobe,
  input logic [2:0] byte_count,
  input logic       frame_end,
  input logic       last
);
  import rwsf_pkg::*;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (byte_count == 3'd1 || byte_count == 3'd2 ||
                byte_count == 3'd3 || byte_count == 3'd4))
    else $error("word byte count out of range");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    strobe && !frame_end |-> byte_count == 3'd4)
    else $error("short word before the end of a frame");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> frame_end)
    else $error("final word of an item does not close a frame");

  a_word_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("word emitted without work in progress");

  a_bad_addr_quick: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == OP_WRITE && reg_addr >= 5'(REGS_PER_CHIP) |=> !busy)
    else $error("write to an unused address kept the block busy");

endmodule

bind register_write_sysex_framer_core rwsf_checker u_rwsf_checker (.*);
